[rtl/core/i2c_master_byte_sequencer_defines.svh]
// Assertion macros shared by the I2C master byte sequencer RTL
`ifndef I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define I2CSEQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define I2CSEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/i2cseq_pkg.sv]
// Types and constants of the I2C master byte sequencer
`timescale 1ns / 1ps

package i2cseq_pkg;

  // Command codes carried by an input item
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_INIT  = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_STOP  = 3'd3;
  localparam logic [2:0] CMD_WRITE = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  // Configuration register map
  localparam int unsigned APB_ADDR_W     = 3;
  localparam int unsigned APB_DATA_W     = 32;
  localparam logic [0:0]  REG_PHASE_TICKS = 1'd0;
  localparam int unsigned PHASE_W        = 16;
  localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET = 16'd50;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_REL_SCL   = 4'd1,
    PH_FINISH    = 4'd2,
    PH_START_A   = 4'd3,
    PH_STOP_A    = 4'd4,
    PH_STOP_B    = 4'd5,
    PH_W_DATA    = 4'd6,
    PH_W_HIGH    = 4'd7,
    PH_W_LOW     = 4'd8,
    PH_W_ACKHIGH = 4'd9,
    PH_R_HIGH    = 4'd10,
    PH_R_LOW     = 4'd11,
    PH_R_ACKSET  = 4'd12,
    PH_R_ACKHIGH = 4'd13,
    PH_R_END     = 4'd14
  } phase_t;

  // One result item
  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       slave_acked;
    logic       timed_out;
  } res_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic counting;
    logic scl_drive;
    logic sda_drive;
  } stat_t;

endpackage

[rtl/core/i2cseq_apb.sv]
// APB configuration register file of the I2C master byte sequencer
`timescale 1ns / 1ps

module i2cseq_apb (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [i2cseq_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [i2cseq_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [i2cseq_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                 pready,
  output logic [i2cseq_pkg::PHASE_W-1:0]       phase_ticks
);

  logic       wr_en;
  logic [0:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[i2cseq_pkg::APB_ADDR_W-1 -: 1];
  assign wr_en   = psel && penable && pwrite && pready &&
                   (reg_idx == i2cseq_pkg::REG_PHASE_TICKS);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cseq_pkg::PHASE_TICKS_RESET;
    end else if (wr_en) begin
      phase_ticks <= pwdata[i2cseq_pkg::PHASE_W-1:0];
    end
  end

  always_comb begin
    if (reg_idx == i2cseq_pkg::REG_PHASE_TICKS) begin
      prdata = i2cseq_pkg::APB_DATA_W'(phase_ticks);
    end else begin
      prdata = '0;
    end
  end

endmodule

[rtl/core/i2cseq_fsm.sv]
// Bit-level sequencer: state registers and one-tick next-state logic
`timescale 1ns / 1ps

module i2cseq_fsm #(
  parameter int unsigned WAIT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [i2cseq_pkg::PHASE_W-1:0]   phase_ticks,
  input  logic [2:0]                       command,
  input  logic [7:0]                       write_data,
  input  logic                             send_ack,
  input  logic                             scl_sense,
  input  logic                             sda_sense,
  output i2cseq_pkg::res_t                 res_next,
  output i2cseq_pkg::stat_t                stat
);

  localparam int unsigned CW = (WAIT_WIDTH > i2cseq_pkg::PHASE_W) ?
                               WAIT_WIDTH : i2cseq_pkg::PHASE_W;

  i2cseq_pkg::phase_t phase, phase_next;
  logic [WAIT_WIDTH-1:0] wait_count, wait_count_next;
  logic [2:0]  bit_position, bit_position_next;
  logic [7:0]  shift_bits, shift_bits_next;
  logic [2:0]  active_command, active_command_next;
  logic        ack_choice, ack_choice_next;
  logic        scl_drive, scl_drive_next;
  logic        sda_drive, sda_drive_next;
  logic [7:0]  last_read, last_read_next;
  logic        last_ack, last_ack_next;
  logic        last_timeout, last_timeout_next;
  logic        done;

  logic                  idle, cmd_ok, counting;
  logic [CW-1:0]         ticks_ext;
  logic [WAIT_WIDTH-1:0] wait_load;
  logic [2:0]            bit_dec;

  assign idle     = (phase == i2cseq_pkg::PH_IDLE);
  assign cmd_ok   = (command >= i2cseq_pkg::CMD_INIT) && (command <= i2cseq_pkg::CMD_READ);
  assign counting = !idle && (wait_count > WAIT_WIDTH'(1));
  assign bit_dec  = bit_position - 3'd1;

  // Wait length: zero counts as one, clamp to the counter's range
  always_comb begin
    ticks_ext = CW'(phase_ticks);
    if (ticks_ext == '0) begin
      ticks_ext = CW'(1);
    end
    if (ticks_ext > CW'({WAIT_WIDTH{1'b1}})) begin
      ticks_ext = CW'({WAIT_WIDTH{1'b1}});
    end
    wait_load = ticks_ext[WAIT_WIDTH-1:0];
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (idle) begin
      if (cmd_ok) begin
        case (command)
          i2cseq_pkg::CMD_INIT:  phase_next = i2cseq_pkg::PH_REL_SCL;
          i2cseq_pkg::CMD_START: phase_next = i2cseq_pkg::PH_START_A;
          i2cseq_pkg::CMD_STOP:  phase_next = i2cseq_pkg::PH_STOP_A;
          i2cseq_pkg::CMD_WRITE: phase_next = i2cseq_pkg::PH_W_DATA;
          default:               phase_next = i2cseq_pkg::PH_REL_SCL;
        endcase
      end
    end else if (!counting) begin
      case (phase)
        i2cseq_pkg::PH_REL_SCL: begin
          if (active_command == i2cseq_pkg::CMD_READ) begin
            phase_next = i2cseq_pkg::PH_R_HIGH;
          end else if (active_command == i2cseq_pkg::CMD_WRITE) begin
            phase_next = i2cseq_pkg::PH_W_ACKHIGH;
          end else begin
            phase_next = i2cseq_pkg::PH_FINISH;
          end
        end
        i2cseq_pkg::PH_START_A: phase_next = i2cseq_pkg::PH_FINISH;
        i2cseq_pkg::PH_STOP_A:  phase_next = i2cseq_pkg::PH_STOP_B;
        i2cseq_pkg::PH_STOP_B:  phase_next = i2cseq_pkg::PH_FINISH;
        i2cseq_pkg::PH_W_DATA:  phase_next = i2cseq_pkg::PH_W_HIGH;
        i2cseq_pkg::PH_W_HIGH:
          phase_next = scl_sense ? i2cseq_pkg::PH_W_LOW : i2cseq_pkg::PH_FINISH;
        i2cseq_pkg::PH_W_LOW:
          phase_next = (bit_position != 3'd0) ? i2cseq_pkg::PH_W_DATA
                                              : i2cseq_pkg::PH_REL_SCL;
        i2cseq_pkg::PH_W_ACKHIGH:
          phase_next = scl_sense ? i2cseq_pkg::PH_FINISH : i2cseq_pkg::PH_IDLE;
        i2cseq_pkg::PH_R_HIGH:
          phase_next = scl_sense ? i2cseq_pkg::PH_R_LOW : i2cseq_pkg::PH_IDLE;
        i2cseq_pkg::PH_R_LOW:
          phase_next = (bit_position != 3'd0) ? i2cseq_pkg::PH_R_HIGH
                                              : i2cseq_pkg::PH_R_ACKSET;
        i2cseq_pkg::PH_R_ACKSET: phase_next = i2cseq_pkg::PH_R_ACKHIGH;
        i2cseq_pkg::PH_R_ACKHIGH:
          phase_next = scl_sense ? i2cseq_pkg::PH_R_END : i2cseq_pkg::PH_FINISH;
        i2cseq_pkg::PH_R_END: phase_next = i2cseq_pkg::PH_FINISH;
        default:              phase_next = i2cseq_pkg::PH_IDLE;
      endcase
    end
  end

  // Line drives, shift data, flags and wait counter
  always_comb begin
    wait_count_next     = wait_count;
    bit_position_next   = bit_position;
    shift_bits_next     = shift_bits;
    active_command_next = active_command;
    ack_choice_next     = ack_choice;
    scl_drive_next      = scl_drive;
    sda_drive_next      = sda_drive;
    last_read_next      = last_read;
    last_ack_next       = last_ack;
    last_timeout_next   = last_timeout;
    done                = 1'b0;

    if (idle) begin
      if (cmd_ok) begin
        active_command_next = command;
        wait_count_next     = wait_load;
        case (command)
          i2cseq_pkg::CMD_INIT:  sda_drive_next = 1'b0;
          i2cseq_pkg::CMD_START: sda_drive_next = 1'b1;
          i2cseq_pkg::CMD_STOP:  sda_drive_next = 1'b1;
          i2cseq_pkg::CMD_WRITE: begin
            last_ack_next     = 1'b0;
            last_timeout_next = 1'b0;
            shift_bits_next   = write_data;
            bit_position_next = i2cseq_pkg::LAST_BIT;
            sda_drive_next    = !write_data[i2cseq_pkg::LAST_BIT];
          end
          default: begin
            last_timeout_next = 1'b0;
            ack_choice_next   = send_ack;
            shift_bits_next   = '0;
            bit_position_next = i2cseq_pkg::LAST_BIT;
            sda_drive_next    = 1'b0;
          end
        endcase
      end
    end else if (counting) begin
      wait_count_next = wait_count - WAIT_WIDTH'(1);
    end else begin
      wait_count_next = (phase_next == i2cseq_pkg::PH_IDLE) ? '0 : wait_load;
      case (phase)
        i2cseq_pkg::PH_REL_SCL: scl_drive_next = 1'b0;
        i2cseq_pkg::PH_START_A: scl_drive_next = 1'b1;
        i2cseq_pkg::PH_STOP_A:  scl_drive_next = 1'b0;
        i2cseq_pkg::PH_STOP_B:  sda_drive_next = 1'b0;
        i2cseq_pkg::PH_W_DATA:  scl_drive_next = 1'b0;
        i2cseq_pkg::PH_W_HIGH: begin
          if (!scl_sense) begin
            last_timeout_next = 1'b1;
            sda_drive_next    = 1'b0;
          end else begin
            scl_drive_next = 1'b1;
          end
        end
        i2cseq_pkg::PH_W_LOW: begin
          if (bit_position != 3'd0) begin
            bit_position_next = bit_dec;
            sda_drive_next    = !shift_bits[bit_dec];
          end else begin
            sda_drive_next = 1'b0;
          end
        end
        i2cseq_pkg::PH_W_ACKHIGH: begin
          if (!scl_sense) begin
            last_timeout_next = 1'b1;
            done              = 1'b1;
          end else begin
            last_ack_next  = !sda_sense;
            scl_drive_next = 1'b1;
          end
        end
        i2cseq_pkg::PH_R_HIGH: begin
          if (!scl_sense) begin
            last_timeout_next = 1'b1;
            done              = 1'b1;
          end else begin
            shift_bits_next = {shift_bits[6:0], sda_sense};
            scl_drive_next  = 1'b1;
          end
        end
        i2cseq_pkg::PH_R_LOW: begin
          if (bit_position != 3'd0) begin
            bit_position_next = bit_dec;
            scl_drive_next    = 1'b0;
          end else begin
            sda_drive_next = ack_choice;
          end
        end
        i2cseq_pkg::PH_R_ACKSET: scl_drive_next = 1'b0;
        i2cseq_pkg::PH_R_ACKHIGH: begin
          if (!scl_sense) begin
            last_timeout_next = 1'b1;
            sda_drive_next    = 1'b0;
          end else begin
            scl_drive_next = 1'b1;
            last_read_next = shift_bits;
          end
        end
        i2cseq_pkg::PH_R_END: sda_drive_next = 1'b0;
        default:              done = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= i2cseq_pkg::PH_IDLE;
      wait_count     <= '0;
      bit_position   <= '0;
      shift_bits     <= '0;
      active_command <= i2cseq_pkg::CMD_NONE;
      ack_choice     <= 1'b0;
      scl_drive      <= 1'b0;
      sda_drive      <= 1'b0;
      last_read      <= '0;
      last_ack       <= 1'b0;
      last_timeout   <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      wait_count     <= wait_count_next;
      bit_position   <= bit_position_next;
      shift_bits     <= shift_bits_next;
      active_command <= active_command_next;
      ack_choice     <= ack_choice_next;
      scl_drive      <= scl_drive_next;
      sda_drive      <= sda_drive_next;
      last_read      <= last_read_next;
      last_ack       <= last_ack_next;
      last_timeout   <= last_timeout_next;
    end
  end

  always_comb begin
    res_next.scl_pull_low = scl_drive_next;
    res_next.sda_pull_low = sda_drive_next;
    res_next.busy_res     = (phase_next != i2cseq_pkg::PH_IDLE);
    res_next.done_res     = done;
    res_next.read_byte    = last_read_next;
    res_next.slave_acked  = last_ack_next;
    res_next.timed_out    = last_timeout_next;
    stat.counting         = counting;
    stat.scl_drive        = scl_drive;
    stat.sda_drive        = sda_drive;
  end

endmodule

[rtl/core/i2cseq_outreg.sv]
// Result register that decouples the input and output handshakes
`timescale 1ns / 1ps

module i2cseq_outreg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              step,
  input  i2cseq_pkg::res_t  res_next,
  output logic              out_valid,
  input  logic              out_ready,
  output i2cseq_pkg::res_t  res_q
);

  // Take a new item whenever the held result is gone or leaves this cycle
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res_next;
    end
  end

endmodule

[rtl/core/i2c_master_byte_sequencer.sv]
// Top level of the I2C master byte sequencer
//
//   channel  | handshake            | carries
//   ---------+----------------------+------------------------------------------
//   input    | in_valid / in_ready  | command, write_data, send_ack, senses
//   output   | out_valid / out_ready| line pulls, busy, done, read/ack/timeout
//   config   | APB psel/penable     | phase_ticks at byte address 0
//
// One item per cycle unless the output stalls: each tick updates the sequencer
// state in the cycle it is accepted, and its result sits in the result register
// from the cycle after. The result register alone sets the rate; a tick is taken
// while a result waits, as long as that result leaves in the same cycle.
// Reset (rst, synchronous) idles the sequencer with both lines released and
// sets phase_ticks to 50. A stalled output holds the input off; no state moves.
`timescale 1ns / 1ps

module i2c_master_byte_sequencer #(
  parameter int unsigned WAIT_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [i2cseq_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [i2cseq_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [i2cseq_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                 pready,
  // tick input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           command,
  input  logic [7:0]                           write_data,
  input  logic                                 send_ack,
  input  logic                                 scl_sense,
  input  logic                                 sda_sense,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 scl_pull_low,
  output logic                                 sda_pull_low,
  output logic                                 busy_res,
  output logic                                 done_res,
  output logic [7:0]                           read_byte,
  output logic                                 slave_acked,
  output logic                                 timed_out
);

`include "i2c_master_byte_sequencer_defines.svh"

  logic [i2cseq_pkg::PHASE_W-1:0] phase_ticks;
  logic                           step;
  i2cseq_pkg::res_t               res_next;
  i2cseq_pkg::res_t               res_q;
  i2cseq_pkg::stat_t              stat;

  // Hold phase_ticks; the user must write only while no item is in flight, the block does not enforce it
  i2cseq_apb u_apb (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .phase_ticks (phase_ticks)
  );

  // Advance the bus sequence by one tick per accepted item
  i2cseq_fsm #(
    .WAIT_WIDTH (WAIT_WIDTH)
  ) u_fsm (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .phase_ticks (phase_ticks),
    .command     (command),
    .write_data  (write_data),
    .send_ack    (send_ack),
    .scl_sense   (scl_sense),
    .sda_sense   (sda_sense),
    .res_next    (res_next),
    .stat        (stat)
  );

  // Register the result and throttle the input on output stalls
  i2cseq_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .step      (step),
    .res_next  (res_next),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_q     (res_q)
  );

  assign scl_pull_low = res_q.scl_pull_low;
  assign sda_pull_low = res_q.sda_pull_low;
  assign busy_res     = res_q.busy_res;
  assign done_res     = res_q.done_res;
  assign read_byte    = res_q.read_byte;
  assign slave_acked  = res_q.slave_acked;
  assign timed_out    = res_q.timed_out;

  // Every accepted tick leaves a result behind it
  `I2CSEQ_ASSERT_NEXT(a_step_gives_result, step, out_valid, "accepted item left no result")

  // A finished sequence never reports itself still busy
  `I2CSEQ_ASSERT_IMP(a_done_not_busy, out_valid && done_res, !busy_res, "done with busy set")

  // Lines stay put while a phase wait is still counting down
  `I2CSEQ_ASSERT_NEXT(a_lines_hold_in_wait, step && stat.counting,
    (stat.scl_drive == $past(stat.scl_drive)) && (stat.sda_drive == $past(stat.sda_drive)),
    "line drive changed during a wait")

endmodule

[tb/i2c_seq_checker.sv]
// Checker for the I2C master byte sequencer: line and status prediction, result compare
`timescale 1ns / 1ps

module i2c_seq_checker #(
  parameter int unsigned WAIT_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [i2cseq_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [i2cseq_pkg::APB_DATA_W-1:0]    pwdata,
  input  logic                                 pready,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [2:0]                           command,
  input  logic [7:0]                           write_data,
  input  logic                                 send_ack,
  input  logic                                 scl_sense,
  input  logic                                 sda_sense,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 scl_pull_low,
  input  logic                                 sda_pull_low,
  input  logic                                 busy_res,
  input  logic                                 done_res,
  input  logic [7:0]                           read_byte,
  input  logic                                 slave_acked,
  input  logic                                 timed_out,
  output int                                   fail_count,
  output int                                   pending,
  output logic                                 seq_idle
);
  import i2cseq_pkg::*;

  localparam logic [APB_ADDR_W-1:0] PHASE_ADDR = APB_ADDR_W'(4 * REG_PHASE_TICKS);
  localparam longint unsigned WAIT_MAX = (64'd1 << WAIT_WIDTH) - 64'd1;

  logic [PHASE_W-1:0]    cfg_ticks;
  logic                  scl_drv;
  logic                  sda_drv;
  phase_t                ph;
  logic [3:0]            bit_pos;
  logic [7:0]            shift_reg;
  logic [WAIT_WIDTH-1:0] wait_cnt;
  logic [2:0]            act_cmd;
  logic                  ack_sel;
  logic [7:0]            last_rd;
  logic                  last_ack;
  logic                  last_to;

  res_t line_state_q[$];
  res_t got;
  res_t want;
  int   result_idx;

  task automatic report_mismatch(input string what, input logic [7:0] seen,
                                 input logic [7:0] wanted);
    $display("%0t: result %0d: %s is %0h, should be %0h", $time, result_idx, what,
             seen, wanted);
    fail_count++;
  endtask

  // Load the wait for the next line change and move to the given phase
  task automatic arm_wait(input phase_t nxt);
    longint unsigned span;
    span = (cfg_ticks == '0) ? 64'd1 : 64'(cfg_ticks);
    if (span > WAIT_MAX) span = WAIT_MAX;
    wait_cnt = WAIT_WIDTH'(span);
    ph = nxt;
  endtask

  task automatic advance_sequencer(input logic [2:0] cmd, input logic [7:0] wd,
                                   input logic sack, input logic scl_hi,
                                   input logic sda_hi, output res_t r);
    logic done;
    done = 1'b0;
    if (ph == PH_IDLE) begin
      if (cmd >= CMD_INIT && cmd <= CMD_READ) begin
        act_cmd = cmd;
        case (cmd)
          CMD_INIT: begin
            sda_drv = 1'b0;
            arm_wait(PH_REL_SCL);
          end
          CMD_START: begin
            sda_drv = 1'b1;
            arm_wait(PH_START_A);
          end
          CMD_STOP: begin
            sda_drv = 1'b1;
            arm_wait(PH_STOP_A);
          end
          CMD_WRITE: begin
            last_ack = 1'b0;
            last_to = 1'b0;
            shift_reg = wd;
            bit_pos = {1'b0, LAST_BIT};
            sda_drv = ~shift_reg[bit_pos[2:0]];
            arm_wait(PH_W_DATA);
          end
          default: begin
            last_to = 1'b0;
            ack_sel = sack;
            shift_reg = '0;
            bit_pos = {1'b0, LAST_BIT};
            sda_drv = 1'b0;
            arm_wait(PH_REL_SCL);
          end
        endcase
      end
    end else if (wait_cnt > 1) begin
      wait_cnt--;
    end else begin
      case (ph)
        PH_REL_SCL: begin
          scl_drv = 1'b0;
          if (act_cmd == CMD_READ) arm_wait(PH_R_HIGH);
          else if (act_cmd == CMD_WRITE) arm_wait(PH_W_ACKHIGH);
          else arm_wait(PH_FINISH);
        end
        PH_START_A: begin
          scl_drv = 1'b1;
          arm_wait(PH_FINISH);
        end
        PH_STOP_A: begin
          scl_drv = 1'b0;
          arm_wait(PH_STOP_B);
        end
        PH_STOP_B: begin
          sda_drv = 1'b0;
          arm_wait(PH_FINISH);
        end
        PH_W_DATA: begin
          scl_drv = 1'b0;
          arm_wait(PH_W_HIGH);
        end
        PH_W_HIGH: begin
          if (!scl_hi) begin
            last_to = 1'b1;
            sda_drv = 1'b0;
            arm_wait(PH_FINISH);
          end else begin
            scl_drv = 1'b1;
            arm_wait(PH_W_LOW);
          end
        end
        PH_W_LOW: begin
          if (bit_pos != 0) begin
            bit_pos = bit_pos - 4'd1;
            sda_drv = ~shift_reg[bit_pos[2:0]];
            arm_wait(PH_W_DATA);
          end else begin
            sda_drv = 1'b0;
            arm_wait(PH_REL_SCL);
          end
        end
        PH_W_ACKHIGH: begin
          if (!scl_hi) begin
            last_to = 1'b1;
            ph = PH_IDLE;
            done = 1'b1;
          end else begin
            last_ack = ~sda_hi;
            scl_drv = 1'b1;
            arm_wait(PH_FINISH);
          end
        end
        PH_R_HIGH: begin
          if (!scl_hi) begin
            last_to = 1'b1;
            ph = PH_IDLE;
            done = 1'b1;
          end else begin
            shift_reg = {shift_reg[6:0], sda_hi};
            scl_drv = 1'b1;
            arm_wait(PH_R_LOW);
          end
        end
        PH_R_LOW: begin
          if (bit_pos != 0) begin
            bit_pos = bit_pos - 4'd1;
            scl_drv = 1'b0;
            arm_wait(PH_R_HIGH);
          end else begin
            sda_drv = ack_sel;
            arm_wait(PH_R_ACKSET);
          end
        end
        PH_R_ACKSET: begin
          scl_drv = 1'b0;
          arm_wait(PH_R_ACKHIGH);
        end
        PH_R_ACKHIGH: begin
          if (!scl_hi) begin
            last_to = 1'b1;
            sda_drv = 1'b0;
            arm_wait(PH_FINISH);
          end else begin
            scl_drv = 1'b1;
            last_rd = shift_reg;
            arm_wait(PH_R_END);
          end
        end
        PH_R_END: begin
          sda_drv = 1'b0;
          arm_wait(PH_FINISH);
        end
        default: begin
          ph = PH_IDLE;
          wait_cnt = '0;
          done = 1'b1;
        end
      endcase
    end
    r = {scl_drv, sda_drv, ph != PH_IDLE, done, last_rd, last_ack, last_to};
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_ticks = PHASE_TICKS_RESET;
      scl_drv = 1'b0;
      sda_drv = 1'b0;
      ph = PH_IDLE;
      bit_pos = '0;
      shift_reg = '0;
      wait_cnt = '0;
      act_cmd = CMD_NONE;
      ack_sel = 1'b0;
      last_rd = '0;
      last_ack = 1'b0;
      last_to = 1'b0;
      line_state_q.delete();
      result_idx = 0;
      fail_count = 0;
    end else begin
      // Retire the oldest expectation before queuing this edge's item
      if (out_valid && out_ready) begin
        got = {scl_pull_low, sda_pull_low, busy_res, done_res, read_byte, slave_acked,
               timed_out};
        if (line_state_q.size() == 0) begin
          report_mismatch("result with nothing expected", got[7:0], '0);
        end else begin
          want = line_state_q.pop_front();
          if (got.scl_pull_low !== want.scl_pull_low)
            report_mismatch("scl_pull_low", 8'(got.scl_pull_low), 8'(want.scl_pull_low));
          if (got.sda_pull_low !== want.sda_pull_low)
            report_mismatch("sda_pull_low", 8'(got.sda_pull_low), 8'(want.sda_pull_low));
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
          if (got.read_byte !== want.read_byte)
            report_mismatch("read_byte", got.read_byte, want.read_byte);
          if (got.slave_acked !== want.slave_acked)
            report_mismatch("slave_acked", 8'(got.slave_acked), 8'(want.slave_acked));
          if (got.timed_out !== want.timed_out)
            report_mismatch("timed_out", 8'(got.timed_out), 8'(want.timed_out));
        end
        result_idx++;
      end
      if (in_valid && in_ready) begin
        advance_sequencer(command, write_data, send_ack, scl_sense, sda_sense, want);
        line_state_q.push_back(want);
      end
      // A write lands after any item of the same edge
      if (psel && penable && pwrite && pready && paddr == PHASE_ADDR)
        cfg_ticks = pwdata[PHASE_W-1:0];
    end
    pending <= line_state_q.size();
    seq_idle <= (ph == PH_IDLE);
  end

endmodule

[tb/tb.sv]
// Testbench top for the I2C master byte sequencer: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb;
  import i2cseq_pkg::*;

  localparam int unsigned WAIT_W = 16;
  // Command codes with no meaning; the block must ignore them
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam logic [APB_ADDR_W-1:0] PHASE_ADDR = APB_ADDR_W'(4 * REG_PHASE_TICKS);
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int NO_LOW = -1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] command = CMD_NONE;
  logic [7:0] write_data = '0;
  logic       send_ack = 1'b0;
  logic       scl_sense = 1'b1;
  logic       sda_sense = 1'b1;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       scl_pull_low;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       slave_acked;
  logic       timed_out;

  int   fail_count;
  int   pending;
  logic seq_idle;

  int burst_left = 0;
  int hold_requests = 0;
  int quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  i2c_master_byte_sequencer #(.WAIT_WIDTH(WAIT_W)) DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .write_data(write_data), .send_ack(send_ack), .scl_sense(scl_sense),
    .sda_sense(sda_sense),
    .out_valid(out_valid), .out_ready(out_ready), .scl_pull_low(scl_pull_low),
    .sda_pull_low(sda_pull_low), .busy_res(busy_res), .done_res(done_res),
    .read_byte(read_byte), .slave_acked(slave_acked), .timed_out(timed_out)
  );

  i2c_seq_checker #(.WAIT_WIDTH(WAIT_W)) u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .write_data(write_data), .send_ack(send_ack), .scl_sense(scl_sense),
    .sda_sense(sda_sense),
    .out_valid(out_valid), .out_ready(out_ready), .scl_pull_low(scl_pull_low),
    .sda_pull_low(sda_pull_low), .busy_res(busy_res), .done_res(done_res),
    .read_byte(read_byte), .slave_acked(slave_acked), .timed_out(timed_out),
    .fail_count(fail_count), .pending(pending), .seq_idle(seq_idle)
  );

  // Offer one tick and hold it until taken. The sender runs in bursts: when a
  // burst is used up, drop valid for a random gap and start a new one. Long
  // bursts give stretches with no gaps at all.
  task automatic send_tick(input logic [2:0] cmd, input logic [7:0] wd, input logic ack,
                           input logic scl_hi, input logic sda_hi);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= cmd;
    write_data <= wd;
    send_ack <= ack;
    scl_sense <= scl_hi;
    sda_sense <= sda_hi;
    do @(posedge clk); while (!in_ready);
  endtask

  // Issue one command on an idle block and tick it through to the end.
  // scl_low_at names the tick (counted from the command) on which SCL is seen
  // low, which lets a chosen clock check fail. SDA follows sda_word bit by
  // tick. busy_cmd rides on the first ticks, while the block is still busy.
  // seq_idle trails by one tick, so the loop stops one idle tick late.
  task automatic run_sequence(input logic [2:0] cmd, input logic [7:0] wd, input logic ack,
                              input int scl_low_at, input logic [31:0] sda_word,
                              input logic [2:0] busy_cmd);
    int k;
    send_tick(cmd, wd, ack, 1'b1, sda_word[0]);
    k = 1;
    do begin
      send_tick((k <= 3) ? busy_cmd : CMD_NONE, 8'($urandom), 1'($urandom),
                k != scl_low_at, sda_word[k % 32]);
      k++;
    end while (!seq_idle);
  endtask

  // Mostly whole command sequences with random content; SCL is rarely seen
  // low so that most transfers finish and a few time out. Stray commands on
  // busy ticks add noise. hold_at asks the receiver for one long hold-off.
  task automatic random_ticks(input int count, input int hold_at);
    logic [2:0] cmd;
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_requests++;
      pick = $urandom_range(0, 99);
      if (seq_idle && pick < 30) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) cmd = CMD_WRITE;
        else if (pick < 70) cmd = CMD_READ;
        else if (pick < 80) cmd = CMD_START;
        else if (pick < 90) cmd = CMD_STOP;
        else if (pick < 95) cmd = CMD_INIT;
        else cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
      end else if (pick >= 96) begin
        cmd = 3'($urandom_range(0, 7));
      end else begin
        cmd = CMD_NONE;
      end
      send_tick(cmd, 8'($urandom), 1'($urandom), $urandom_range(0, 63) != 0,
                1'($urandom));
    end
  endtask

  // Stop offering and hold until every expected result has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_phase_ticks(input logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PHASE_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Receiver: runs of always-ready, coin-flip and mostly-stalled cycles, plus
  // a long hold-off on request that lets the block fill and stall its input.
  initial begin
    int run_left;
    int mode;
    int holds_done;
    run_left = 0;
    mode = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_requests > holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (run_left == 0) begin
        mode = $urandom_range(0, 2);
        run_left = $urandom_range(4, 120);
      end
      run_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom);
        default: out_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** i2c_master_byte_sequencer: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset value of the wait: a start sequence at 50 ticks per change
    run_sequence(CMD_START, 8'h00, 1'b0, NO_LOW, 32'hFFFF_FFFF, CMD_NONE);

    // Zero wait counts as one tick; the directed cases below rely on that
    settle();
    write_phase_ticks('0);
    run_sequence(CMD_INIT, 8'h00, 1'b0, NO_LOW, 32'hFFFF_FFFF, CMD_NONE);
    run_sequence(CMD_START, 8'h00, 1'b0, NO_LOW, 32'hFFFF_FFFF, CMD_NONE);
    // Write all ones, slave acks; a read offered while busy is ignored
    run_sequence(CMD_WRITE, 8'hFF, 1'b0, NO_LOW, 32'h0000_0000, CMD_READ);
    // Write all zeros, no acknowledge
    run_sequence(CMD_WRITE, 8'h00, 1'b1, NO_LOW, 32'hFFFF_FFFF, CMD_NONE);
    // Write with SCL held low on the first data bit, the last data bit and
    // the acknowledge slot
    run_sequence(CMD_WRITE, 8'hA5, 1'b0, 2, 32'h0000_0000, CMD_NONE);
    run_sequence(CMD_WRITE, 8'h81, 1'b0, 23, 32'h0000_0000, CMD_NONE);
    run_sequence(CMD_WRITE, 8'h5A, 1'b0, 26, 32'h0000_0000, CMD_NONE);
    // Reads with ACK and NAK over mixed, all-high and all-low data
    run_sequence(CMD_READ, 8'h00, 1'b1, NO_LOW, 32'hA5A5_5A5A, CMD_START);
    run_sequence(CMD_READ, 8'hFF, 1'b0, NO_LOW, 32'hFFFF_FFFF, CMD_NONE);
    run_sequence(CMD_READ, 8'h00, 1'b1, NO_LOW, 32'h0000_0000, CMD_NONE);
    // Read timeouts: first data bit, last data bit, acknowledge slot; the
    // aborted reads must leave the last good byte in place
    run_sequence(CMD_READ, 8'h00, 1'b1, 2, 32'h3C3C_C3C3, CMD_NONE);
    run_sequence(CMD_READ, 8'h00, 1'b0, 16, 32'h3C3C_C3C3, CMD_NONE);
    run_sequence(CMD_READ, 8'h00, 1'b1, 19, 32'h3C3C_C3C3, CMD_NONE);
    // Stop and init ignore SCL entirely
    run_sequence(CMD_STOP, 8'h00, 1'b0, 1, 32'h0000_0000, CMD_NONE);
    run_sequence(CMD_INIT, 8'h00, 1'b0, 1, 32'h0000_0000, CMD_NONE);
    // Codes that must leave the block idle
    run_sequence(CMD_SPARE6, 8'hFF, 1'b1, NO_LOW, 32'h0000_0000, CMD_NONE);
    run_sequence(CMD_SPARE7, 8'h00, 1'b0, NO_LOW, 32'hFFFF_FFFF, CMD_NONE);
    run_sequence(CMD_NONE, 8'h55, 1'b1, NO_LOW, 32'h0000_0000, CMD_NONE);

    // Upper data bits must not reach the 16-bit wait register
    settle();
    write_phase_ticks(32'hFFFF_0002);
    random_ticks(550, 250);

    settle();
    write_phase_ticks(32'd1);
    random_ticks(500, NO_LOW);

    settle();
    write_phase_ticks(32'd3);
    random_ticks(550, NO_LOW);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** i2c_master_byte_sequencer: PASSED **");
    end else begin
      $display("** i2c_master_byte_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
